[design/ntcgc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ntcgc_pkg;

    localparam int ROM_ENTRIES = 131;
    localparam int TABLE_ROWS_DEF = 131;
    localparam int ROM_W = 18;
    localparam int CFG_W = 20;
    localparam int IDX_W = 2;
    localparam int CUR_MAX = 4095;
    localparam int RES_MAX = 4194303;

    localparam logic [IDX_W-1:0] REG_PULLUP_V = 2'd0;
    localparam logic [IDX_W-1:0] REG_PULLUP_R = 2'd1;
    localparam logic [IDX_W-1:0] REG_COMP_R   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_COLD = 2'd1;
    localparam logic [1:0] ST_HOT  = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    // unsigned restoring divider request
    typedef struct packed {
        logic        go;
        logic [35:0] num;
        logic [23:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [35:0] quo;
    } t_div_rsp;

    function automatic logic [ROM_W-1:0] rom_value(input logic [7:0] idx);
        logic [ROM_W-1:0] v;
        unique case (idx)
            8'd0: v = 18'd205200;   8'd1: v = 18'd193800;   8'd2: v = 18'd183100;
            8'd3: v = 18'd173100;   8'd4: v = 18'd163600;   8'd5: v = 18'd154800;
            8'd6: v = 18'd146500;   8'd7: v = 18'd138700;   8'd8: v = 18'd131300;
            8'd9: v = 18'd124400;   8'd10: v = 18'd117900;  8'd11: v = 18'd111800;
            8'd12: v = 18'd106000;  8'd13: v = 18'd100600;  8'd14: v = 18'd95510;
            8'd15: v = 18'd90690;   8'd16: v = 18'd86150;   8'd17: v = 18'd81860;
            8'd18: v = 18'd77810;   8'd19: v = 18'd73990;   8'd20: v = 18'd70370;
            8'd21: v = 18'd66960;   8'd22: v = 18'd63740;   8'd23: v = 18'd60690;
            8'd24: v = 18'd57800;   8'd25: v = 18'd55070;   8'd26: v = 18'd52490;
            8'd27: v = 18'd50040;   8'd28: v = 18'd47720;   8'd29: v = 18'd45520;
            8'd30: v = 18'd43440;   8'd31: v = 18'd41460;   8'd32: v = 18'd39590;
            8'd33: v = 18'd37810;   8'd34: v = 18'd36130;   8'd35: v = 18'd34530;
            8'd36: v = 18'd33000;   8'd37: v = 18'd31560;   8'd38: v = 18'd30190;
            8'd39: v = 18'd28880;   8'd40: v = 18'd27640;   8'd41: v = 18'd26460;
            8'd42: v = 18'd25330;   8'd43: v = 18'd24260;   8'd44: v = 18'd23240;
            8'd45: v = 18'd22270;   8'd46: v = 18'd21350;   8'd47: v = 18'd20470;
            8'd48: v = 18'd19630;   8'd49: v = 18'd18830;   8'd50: v = 18'd18060;
            8'd51: v = 18'd17340;   8'd52: v = 18'd16640;   8'd53: v = 18'd15980;
            8'd54: v = 18'd15350;   8'd55: v = 18'd14740;   8'd56: v = 18'd14170;
            8'd57: v = 18'd13620;   8'd58: v = 18'd13090;   8'd59: v = 18'd12590;
            8'd60: v = 18'd12110;   8'd61: v = 18'd11650;   8'd62: v = 18'd11210;
            8'd63: v = 18'd10790;   8'd64: v = 18'd10380;   8'd65: v = 18'd10000;
            8'd66: v = 18'd9632;    8'd67: v = 18'd9279;    8'd68: v = 18'd8942;
            8'd69: v = 18'd8619;    8'd70: v = 18'd8309;    8'd71: v = 18'd8012;
            8'd72: v = 18'd7727;    8'd73: v = 18'd7454;    8'd74: v = 18'd7192;
            8'd75: v = 18'd6941;    8'd76: v = 18'd6700;    8'd77: v = 18'd6468;
            8'd78: v = 18'd6246;    8'd79: v = 18'd6033;    8'd80: v = 18'd5828;
            8'd81: v = 18'd5631;    8'd82: v = 18'd5441;    8'd83: v = 18'd5259;
            8'd84: v = 18'd5084;    8'd85: v = 18'd4916;    8'd86: v = 18'd4754;
            8'd87: v = 18'd4598;    8'd88: v = 18'd4448;    8'd89: v = 18'd4304;
            8'd90: v = 18'd4165;    8'd91: v = 18'd4031;    8'd92: v = 18'd3902;
            8'd93: v = 18'd3778;    8'd94: v = 18'd3658;    8'd95: v = 18'd3543;
            8'd96: v = 18'd3432;    8'd97: v = 18'd3325;    8'd98: v = 18'd3222;
            8'd99: v = 18'd3123;    8'd100: v = 18'd3027;   8'd101: v = 18'd2934;
            8'd102: v = 18'd2845;   8'd103: v = 18'd2759;   8'd104: v = 18'd2676;
            8'd105: v = 18'd2595;   8'd106: v = 18'd2518;   8'd107: v = 18'd2443;
            8'd108: v = 18'd2371;   8'd109: v = 18'd2301;   8'd110: v = 18'd2233;
            8'd111: v = 18'd2168;   8'd112: v = 18'd2105;   8'd113: v = 18'd2045;
            8'd114: v = 18'd1986;   8'd115: v = 18'd1929;   8'd116: v = 18'd1874;
            8'd117: v = 18'd1821;   8'd118: v = 18'd1770;   8'd119: v = 18'd1720;
            8'd120: v = 18'd1672;   8'd121: v = 18'd1625;   8'd122: v = 18'd1580;
            8'd123: v = 18'd1536;   8'd124: v = 18'd1493;   8'd125: v = 18'd1451;
            8'd126: v = 18'd1411;   8'd127: v = 18'd1372;   8'd128: v = 18'd1334;
            8'd129: v = 18'd1297;   8'd130: v = 18'd1261;
            default: v = 18'd1261;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/ntcgc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// bit-serial restoring divider, one quotient bit per cycle
module ntcgc_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ntcgc_pkg::t_div_req  i_req,
    output ntcgc_pkg::t_div_rsp  o_rsp
);
    import ntcgc_pkg::*;

    logic [35:0] r_quo, n_quo;
    logic [24:0] r_rem, n_rem;
    logic [23:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [24:0] w_trial;
    logic [24:0] w_diff;

    assign w_trial = {r_rem[23:0], r_quo[35]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.go) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[24]) begin
                n_rem = w_diff;
                n_quo = {r_quo[34:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[34:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd35) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 6'd36) else $error("divider count overrun");

endmodule
`default_nettype wire

[design/ntc_temperature_ground_comp.sv]
`timescale 1ns / 1ps
`default_nettype none
// a zero-current reading ends after the first division, a table clamp after the second division and
//   the first search step; an interpolated reading passes through three serial divisions, a product
//   stage and the table search steps
// throughput: one item at a time; busy is high from start until the cycle after o_valid
// the result shows for one cycle on o_valid; the receiver cannot stall
// reset: synchronous active-low; state, control and configuration registers reset, datapath registers do not
module ntc_temperature_ground_comp #(
    parameter int TABLE_ROWS = ntcgc_pkg::TABLE_ROWS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_cfg_we,
    input  wire  [ntcgc_pkg::IDX_W-1:0]        i_cfg_idx,
    input  wire  [ntcgc_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire  [11:0]                        i_adc_voltage_mv,
    input  wire  signed [14:0]                 i_battery_current_ma,
    output logic                               o_valid,
    output logic signed [10:0]                 o_temperature_dc,
    output logic [21:0]                        o_ntc_resistance_ohm,
    output logic [11:0]                        o_ntc_current_ua,
    output logic [1:0]                         o_status
);
    import ntcgc_pkg::*;

    localparam int USED = (TABLE_ROWS < ROM_ENTRIES) ? TABLE_ROWS : ROM_ENTRIES;
    localparam logic [7:0] LAST = 8'(USED - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_DIV1 = 8'b00000010,
        S_MUL  = 8'b00000100,
        S_DIV2 = 8'b00001000,
        S_SRCH = 8'b00010000,
        S_DIV3 = 8'b00100000,
        S_OUT  = 8'b01000000,
        S_FIN  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [11:0] r_pv;
    logic [19:0] r_pr;
    logic [15:0] r_cr;
    logic [11:0] r_adc;
    logic signed [14:0] r_ibat;
    logic r_neg;
    logic [11:0] r_cur;
    logic [21:0] r_res;
    logic [7:0] r_lo, r_hi;
    logic signed [10:0] r_temp;
    logic [1:0] r_status;
    logic signed [31:0] r_drop;
    logic [1:0] r_mcnt;
    logic r_valid;

    t_div_req w_dreq;
    t_div_rsp w_rsp;

    ntcgc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_rsp));

    // current numerator and rounding
    logic signed [12:0] w_dv;
    logic [22:0] w_num1_mag;
    assign w_dv = $signed({1'b0, r_pv}) - $signed({1'b0, r_adc});
    assign w_num1_mag = 23'(w_dv[11:0]) * 23'd1000 + 23'(r_pr[19:1]);

    // resistance numerator: adc*10000 - ibat*cr
    logic signed [33:0] w_n2;
    logic [33:0] w_n2_mag;
    logic [16:0] w_d2;
    assign w_n2 = $signed(34'(r_adc) * 34'd10000) - 34'(r_drop);
    assign w_d2 = 17'(r_cur) * 17'd10;
    assign w_n2_mag = (w_n2[33] ? -w_n2 : w_n2) + 34'(w_d2[16:1]);

    logic [35:0] w_q;
    assign w_q = w_rsp.quo;

    logic [7:0] w_mid;
    logic [ROM_W-1:0] w_rmid, w_rlo, w_rhi, w_r0, w_rl;
    assign w_mid = 8'((9'(r_lo) + 9'(r_hi)) >> 1);
    assign w_rmid = rom_value(w_mid);
    assign w_rlo = rom_value(r_lo);
    assign w_rhi = rom_value(r_hi);
    assign w_r0 = rom_value(8'd0);
    assign w_rl = rom_value(LAST);

    logic [ROM_W-1:0] w_span;
    logic [22:0] w_n3;
    assign w_span = w_rlo - w_rhi;
    assign w_n3 = 23'(w_rlo - ROM_W'(r_res)) * 23'd10 + 23'(w_span[ROM_W-1:1]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) begin
                n_state = S_DIV1;
            end
            S_DIV1: ;
            S_MUL: if (r_mcnt == 2'd2) begin
                n_state = S_DIV2;
            end
            S_DIV2: ;
            S_SRCH: if (r_hi - r_lo <= 8'd1) begin
                n_state = S_DIV3;
            end
            S_DIV3: ;
            S_OUT: n_state = S_FIN;
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv <= 12'd1800;
            r_pr <= 20'd100000;
            r_cr <= 16'd0;
            r_valid <= 1'b0;
            r_mcnt <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PULLUP_V) r_pv <= i_cfg_data[11:0];
                if (i_cfg_idx == REG_PULLUP_R) r_pr <= i_cfg_data;
                if (i_cfg_idx == REG_COMP_R)   r_cr <= i_cfg_data[15:0];
            end
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_state <= S_DIV1;
                    r_adc <= i_adc_voltage_mv;
                    r_ibat <= i_battery_current_ma;
                end
                S_DIV1: if (w_rsp.done) begin
                    // negative numerator, zero divisor or zero quotient means no current
                    if (r_neg || r_pr == 20'd0 || w_q == 36'd0) begin
                        r_temp <= -11'sd400;
                        r_res <= '0;
                        r_cur <= '0;
                        r_status <= ST_ZERO;
                        r_state <= S_OUT;
                    end else begin
                        r_cur <= (w_q > 36'(CUR_MAX)) ? 12'(CUR_MAX) : w_q[11:0];
                        r_mcnt <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    r_drop <= 32'(r_ibat) * $signed({16'd0, r_cr});
                    r_state <= n_state;
                end
                S_DIV2: if (w_rsp.done) begin
                    if (r_neg) r_res <= '0;
                    else if (w_q > 36'(RES_MAX)) r_res <= 22'(RES_MAX);
                    else r_res <= w_q[21:0];
                    r_lo <= 8'd0;
                    r_hi <= LAST;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_res > 22'(w_r0)) begin
                        r_temp <= -11'sd400;
                        r_status <= ST_COLD;
                        r_state <= S_OUT;
                    end else if (r_res < 22'(w_rl)) begin
                        r_temp <= 11'(-400 + 10 * (USED - 1));
                        r_status <= ST_HOT;
                        r_state <= S_OUT;
                    end else if (r_hi - r_lo > 8'd1) begin
                        if (22'(w_rmid) >= r_res) r_lo <= w_mid;
                        else r_hi <= w_mid;
                    end else begin
                        r_status <= ST_OK;
                        r_temp <= 11'(-400 + 10 * 32'(r_lo));
                        r_state <= S_DIV3;
                    end
                end
                S_DIV3: if (w_rsp.done) begin
                    r_temp <= r_temp + 11'(w_q[10:0]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_FIN;
                end
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // divider launches, sequenced by state entry
    logic r_go;
    logic [35:0] r_gnum;
    logic [23:0] r_gden;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
            r_neg <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_state == S_IDLE && start) begin
                r_go <= 1'b1;
            end else if (r_state == S_MUL && r_mcnt == 2'd2) begin
                r_go <= 1'b1;
            end else if (r_state == S_SRCH && n_state == S_DIV3
                         && r_res <= 22'(w_r0) && r_res >= 22'(w_rl)) begin
                r_go <= 1'b1;
            end
            if (r_state == S_DIV1 && r_go) begin
                r_neg <= w_dv[12];
            end else if (r_state == S_MUL && r_mcnt == 2'd2) begin
                r_neg <= w_n2[33];
            end
        end
        if (r_state == S_DIV1 && r_go) begin
            r_gnum <= 36'(w_num1_mag);
            r_gden <= 24'(r_pr);
        end else if (r_state == S_MUL) begin
            r_gnum <= 36'(w_n2_mag);
            r_gden <= 24'(w_d2);
        end else if (r_state == S_SRCH) begin
            r_gnum <= 36'(w_n3);
            r_gden <= (w_span == '0) ? 24'd1 : 24'(w_span);
        end
    end

    // first division needs the captured input, so its launch passes through the extra register r_go1
    logic r_go1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_go1 <= 1'b0;
        else r_go1 <= (r_state == S_DIV1) && r_go;
    end

    assign w_dreq.go  = r_go1 || (r_go && r_state != S_DIV1);
    assign w_dreq.num = r_gnum;
    assign w_dreq.den = r_gden;

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_temperature_dc = r_temp;
    assign o_ntc_resistance_ohm = r_res;
    assign o_ntc_current_ua = r_cur;
    assign o_status = r_status;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("result held");
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_ZERO) |-> (r_cur == 12'd0 && r_res == 22'd0))
        else $error("zero current fields");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo < r_hi)) else $error("search bounds");

endmodule
`default_nettype wire
